// ===== src/mce_pkg.sv =====
// Package with the shared types, constants and pattern table of the Morse encoder.
package mce_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned DurW   = 3;
    localparam int unsigned ElemW  = 5;
    localparam int unsigned CountW = 3;
    localparam int unsigned TdataW = 8;

    localparam logic [DurW-1:0] DurDot      = 3'd1;
    localparam logic [DurW-1:0] DurDash     = 3'd3;
    localparam logic [DurW-1:0] DurElemGap  = 3'd1;
    localparam logic [DurW-1:0] DurLetterEx = 3'd2;
    localparam logic [DurW-1:0] DurWordGap  = 3'd6;

    typedef enum logic [1:0] {
        K_NONE,
        K_SPACE,
        K_CHAR
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_MARK,
        S_SPACE,
        S_GAP,
        S_WORD
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MARK,
        OP_SPACE,
        OP_GAP,
        OP_WORD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  out_free;
        logic  elems_done;
    } t_status;

    // Elements are left aligned: the first element sits in the top bit, 1 = dash.
    typedef struct packed {
        t_kind             kind;
        logic [CountW-1:0] count;
        logic [ElemW-1:0]  bits;
    } t_pattern;

    function automatic t_pattern lookup(input logic [CharW-1:0] c);
        t_pattern p;
        p.kind  = K_CHAR;
        p.count = 3'd0;
        p.bits  = 5'b00000;
        case (c)
            " ": p.kind = K_SPACE;
            "A": begin p.count = 3'd2; p.bits = 5'b01000; end
            "B": begin p.count = 3'd4; p.bits = 5'b10000; end
            "C": begin p.count = 3'd4; p.bits = 5'b10100; end
            "D": begin p.count = 3'd3; p.bits = 5'b10000; end
            "E": begin p.count = 3'd1; p.bits = 5'b00000; end
            "F": begin p.count = 3'd4; p.bits = 5'b00100; end
            "G": begin p.count = 3'd3; p.bits = 5'b11000; end
            "H": begin p.count = 3'd4; p.bits = 5'b00000; end
            "I": begin p.count = 3'd2; p.bits = 5'b00000; end
            "J": begin p.count = 3'd4; p.bits = 5'b01110; end
            "K": begin p.count = 3'd3; p.bits = 5'b10100; end
            "L": begin p.count = 3'd4; p.bits = 5'b01000; end
            "M": begin p.count = 3'd2; p.bits = 5'b11000; end
            "N": begin p.count = 3'd2; p.bits = 5'b10000; end
            "O": begin p.count = 3'd3; p.bits = 5'b11100; end
            "P": begin p.count = 3'd4; p.bits = 5'b01100; end
            "Q": begin p.count = 3'd4; p.bits = 5'b11010; end
            "R": begin p.count = 3'd3; p.bits = 5'b01000; end
            "S": begin p.count = 3'd3; p.bits = 5'b00000; end
            "T": begin p.count = 3'd1; p.bits = 5'b10000; end
            "U": begin p.count = 3'd3; p.bits = 5'b00100; end
            "V": begin p.count = 3'd4; p.bits = 5'b00010; end
            "W": begin p.count = 3'd3; p.bits = 5'b01100; end
            "X": begin p.count = 3'd4; p.bits = 5'b10010; end
            "Y": begin p.count = 3'd4; p.bits = 5'b10110; end
            "Z": begin p.count = 3'd4; p.bits = 5'b11000; end
            "0": begin p.count = 3'd5; p.bits = 5'b11111; end
            "1": begin p.count = 3'd5; p.bits = 5'b01111; end
            "2": begin p.count = 3'd5; p.bits = 5'b00111; end
            "3": begin p.count = 3'd5; p.bits = 5'b00011; end
            "4": begin p.count = 3'd5; p.bits = 5'b00001; end
            "5": begin p.count = 3'd5; p.bits = 5'b00000; end
            "6": begin p.count = 3'd5; p.bits = 5'b10000; end
            "7": begin p.count = 3'd5; p.bits = 5'b11000; end
            "8": begin p.count = 3'd5; p.bits = 5'b11100; end
            "9": begin p.count = 3'd5; p.bits = 5'b11110; end
            default: p.kind = K_NONE;
        endcase
        return p;
    endfunction

endpackage

// ===== src/mce_ctrl.sv =====
// Controller state machine that sequences the intervals of one character.
module mce_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  mce_pkg::t_status i_status,
    output logic             o_ready,
    output mce_pkg::t_cmd    o_cmd
);
    import mce_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_state = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                case (i_status.kind)
                    K_SPACE: n_state = S_WORD;
                    K_CHAR:  n_state = S_MARK;
                    default: n_state = S_IDLE;
                endcase
            end
            S_MARK: begin
                if (i_status.out_free) begin
                    n_state = S_SPACE;
                end
            end
            S_SPACE: begin
                if (i_status.out_free) begin
                    n_state = i_status.elems_done ? S_GAP : S_MARK;
                end
            end
            S_GAP, S_WORD: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_accept) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            S_MARK: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_MARK;
                end
            end
            S_SPACE: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_SPACE;
                end
            end
            S_GAP: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_GAP;
                end
            end
            S_WORD: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_WORD;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== src/mce_dp.sv =====
// Datapath with the pattern shifter, element counter and output register.
module mce_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mce_pkg::t_cmd               i_cmd,
    input  logic [mce_pkg::CharW-1:0]   i_char,
    input  logic                        i_out_ready,
    output mce_pkg::t_status            o_status,
    output logic                        o_out_valid,
    output logic                        o_light_on,
    output logic [mce_pkg::DurW-1:0]    o_duration,
    output logic                        o_last
);
    import mce_pkg::*;

    t_pattern          n_pat;
    t_kind             r_kind;
    logic [CountW-1:0] r_count;
    logic [ElemW-1:0]  r_bits;
    logic              r_valid;
    logic              r_light;
    logic [DurW-1:0]   r_dur;
    logic              r_last;
    logic              w_emit;

    assign n_pat  = lookup(i_char);
    assign w_emit = (i_cmd.op == OP_MARK) || (i_cmd.op == OP_SPACE)
                 || (i_cmd.op == OP_GAP)  || (i_cmd.op == OP_WORD);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_kind  <= n_pat.kind;
                r_count <= n_pat.count;
                r_bits  <= n_pat.bits;
            end
            OP_MARK: begin
                r_count <= r_count - 3'd1;
                r_bits  <= {r_bits[ElemW-2:0], 1'b0};
            end
            default: r_count <= r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_MARK: begin
                r_light <= 1'b1;
                r_dur   <= r_bits[ElemW-1] ? DurDash : DurDot;
                r_last  <= 1'b0;
            end
            OP_SPACE: begin
                r_light <= 1'b0;
                r_dur   <= DurElemGap;
                r_last  <= 1'b0;
            end
            OP_GAP: begin
                r_light <= 1'b0;
                r_dur   <= DurLetterEx;
                r_last  <= 1'b1;
            end
            OP_WORD: begin
                r_light <= 1'b0;
                r_dur   <= DurWordGap;
                r_last  <= 1'b1;
            end
            default: r_dur <= r_dur;
        endcase
    end

    assign o_status.kind       = r_kind;
    assign o_status.out_free   = !r_valid || i_out_ready;
    assign o_status.elems_done = (r_count == 3'd0);

    assign o_out_valid = r_valid;
    assign o_light_on  = r_light;
    assign o_duration  = r_dur;
    assign o_last      = r_last;

endmodule

// ===== src/morse_character_encoder.sv =====
// Top level of the Morse character encoder: ASCII characters in, light intervals out.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[7:0] = char_code
//  m_axis    out        tdata[0] = light_on, tdata[3:1] = duration_units, tlast = last_interval
//
// One character is taken at a time. After the accepting beat, a classify state inspects the
// character, then the sequencer emits one interval per cycle while m_axis does not stall:
// up to 11 result beats for a digit, one for a space and none for an unknown code.
// Reset is synchronous and active low and clears the state machine and output valid.
// A stall on m_axis holds the sequencer; the output register frees as its beat is taken.
module morse_character_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [mce_pkg::TdataW-1:0]  s_axis_tdata,  // [7:0] char_code
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [mce_pkg::TdataW-1:0]  m_axis_tdata,  // [0] light_on, [3:1] duration_units
    output logic                        m_axis_tlast
);
    import mce_pkg::*;

    t_cmd            w_cmd;
    t_status         w_status;
    logic            w_accept;
    logic            w_light;
    logic [DurW-1:0] w_dur;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    mce_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_status (w_status),
        .o_ready  (s_axis_tready),
        .o_cmd    (w_cmd)
    );

    mce_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_char      (s_axis_tdata[CharW-1:0]),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_light_on  (w_light),
        .o_duration  (w_dur),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{(TdataW-DurW-1){1'b0}}, w_dur, w_light};

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the Morse character encoder: stream stimulus, prediction and checks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HoldCycles    = 300;
    localparam int WatchdogLimit = 4000;
    localparam int TailCycles    = 30;
    localparam int MaxReports    = 10;
    localparam int PhaseItems    = 60;

    localparam logic [2:0] UnitsDot       = 3'd1;
    localparam logic [2:0] UnitsDash      = 3'd3;
    localparam logic [2:0] UnitsElemGap   = 3'd1;
    localparam logic [2:0] UnitsLetterEnd = 3'd2;
    localparam logic [2:0] UnitsWordGap   = 3'd6;

    typedef struct packed {
        logic       lit;
        logic [2:0] units;
        logic       closing;
    } t_interval;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [mce_pkg::TdataW-1:0] s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [mce_pkg::TdataW-1:0] m_axis_tdata;
    logic                       m_axis_tlast;

    t_interval pending_intervals[$];
    int        idle_pct = 0;
    int        stall_pct = 0;
    bit        hold_armed = 1'b0;
    int        hold_count = 0;
    int        quiet_cycles = 0;
    int        mismatches = 0;
    int        chars_sent = 0;
    int        keyed_sent = 0;
    int        intervals_seen = 0;

    morse_character_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic string elements_of(input logic [7:0] c);
        case (c)
            "A": return ".-";
            "B": return "-...";
            "C": return "-.-.";
            "D": return "-..";
            "E": return ".";
            "F": return "..-.";
            "G": return "--.";
            "H": return "....";
            "I": return "..";
            "J": return ".---";
            "K": return "-.-";
            "L": return ".-..";
            "M": return "--";
            "N": return "-.";
            "O": return "---";
            "P": return ".--.";
            "Q": return "--.-";
            "R": return ".-.";
            "S": return "...";
            "T": return "-";
            "U": return "..-";
            "V": return "...-";
            "W": return ".--";
            "X": return "-..-";
            "Y": return "-.--";
            "Z": return "--..";
            "0": return "-----";
            "1": return ".----";
            "2": return "..---";
            "3": return "...--";
            "4": return "....-";
            "5": return ".....";
            "6": return "-....";
            "7": return "--...";
            "8": return "---..";
            "9": return "----.";
            default: return "";
        endcase
    endfunction

    function automatic bit is_keyed(input logic [7:0] c);
        return (c == " ") || (elements_of(c).len() > 0);
    endfunction

    function automatic void queue_intervals(input logic [7:0] c);
        string els;
        int    i;
        if (c == " ") begin
            pending_intervals.push_back('{1'b0, UnitsWordGap, 1'b1});
            return;
        end
        els = elements_of(c);
        if (els.len() == 0) begin
            return;
        end
        for (i = 0; i < els.len(); i++) begin
            pending_intervals.push_back('{1'b1, (els[i] == "-") ? UnitsDash : UnitsDot, 1'b0});
            pending_intervals.push_back('{1'b0, UnitsElemGap, 1'b0});
        end
        pending_intervals.push_back('{1'b0, UnitsLetterEnd, 1'b1});
    endfunction

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 8);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        queue_intervals(c);
        chars_sent++;
        if (is_keyed(c)) begin
            keyed_sent++;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_intervals.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 15) begin
            return " ";
        end else if (r < 60) begin
            return 8'h41 + 8'($urandom_range(25));
        end else if (r < 80) begin
            return 8'h30 + 8'($urandom_range(9));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic test_directed();
        logic [7:0] probes[$];
        int         i;
        probes = '{8'h00, 8'hFF, 8'h80, 8'h7F, " ", "A", "D", "E", "T", "0", "5", "9",
                   "Z", "a", "d", "z", 8'h40, 8'h5B, 8'h2F, 8'h3A, "H", "Q", " ", "1"};
        idle_pct  = 0;
        stall_pct = 0;
        for (i = 0; i < probes.size(); i++) begin
            send_char(probes[i]);
        end
        wait_drained();
    endtask

    task automatic test_random_words(input int sender_idle, input int receiver_stall);
        int         keyed;
        logic [7:0] c;
        keyed     = 0;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        while (keyed < PhaseItems) begin
            c = pick_char();
            send_char(c);
            if (is_keyed(c)) begin
                keyed++;
            end
        end
        wait_drained();
    endtask

    task automatic test_output_hold();
        int i;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_armed = 1'b1;
        for (i = 0; i < 10; i++) begin
            send_char(8'h30 + 8'($urandom_range(9)));
        end
        wait_drained();
        hold_armed = 1'b0;
    endtask

    // Once a hold is armed, the receiver first holds off, then returns to random stalls.
    always @(posedge i_clk) begin
        if (hold_armed && hold_count < HoldCycles) begin
            m_axis_tready <= 1'b0;
            hold_count    <= hold_count + 1;
        end else begin
            if (!hold_armed) begin
                hold_count <= 0;
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_interval want;
        t_interval got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tlast};
            intervals_seen++;
            if (pending_intervals.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReports) begin
                    $display("Unexpected beat: lit=%0b units=%0d last=%0b",
                             got.lit, got.units, got.closing);
                end
            end else begin
                want = pending_intervals.pop_front();
                if (got.lit != want.lit || got.units != want.units
                        || got.closing != want.closing) begin
                    mismatches++;
                    if (mismatches <= MaxReports) begin
                        $display("Beat %0d: expected lit=%0b units=%0d last=%0b",
                                 intervals_seen, want.lit, want.units, want.closing,
                                 ", got lit=%0b units=%0d last=%0b",
                                 got.lit, got.units, got.closing);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("Watchdog: no beat moved for %0d cycles.", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_words(0, 0);
        test_random_words(53, 0);
        test_random_words(0, 53);
        test_random_words(22, 22);
        test_output_hold();
        $display("Sent %0d characters, %0d of them keyable, and checked %0d intervals.",
                 chars_sent, keyed_sent, intervals_seen);
        $display("Covered edge codes, all idling mixes and a long output stall.");
        if (mismatches == 0 && pending_intervals.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
